// ===== hw/rtl/tgr_pkg.sv =====
package tgr_pkg;

   localparam int MAX_GLYPHS      = 256;
   localparam int MAX_LINES       = 16;
   localparam int BYTES_PER_PIXEL = 4;

   localparam int LINE_SLOTS   = 16;
   localparam int LINE_W       = $clog2(LINE_SLOTS);
   localparam int HEIGHT_LIMIT = (MAX_LINES < LINE_SLOTS) ? MAX_LINES : LINE_SLOTS;
   localparam int FONT_DEPTH   = 4096;
   localparam int FONT_AW      = $clog2(FONT_DEPTH);
   localparam int MARGIN_CELLS = 4;
   localparam int OFFS_W       = 26;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PW    = $clog2(CMD_DEPTH);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PW    = $clog2(RSP_DEPTH);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_FIRST   = 8'h20;
   localparam logic [7:0] CHAR_LAST    = 8'h7E;

   typedef enum logic [1:0] {
      FUNC_PRINT = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_HOME  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      CSR_PITCH        = 3'd0,
      CSR_CHARS        = 3'd1,
      CSR_GLYPH_WIDTH  = 3'd2,
      CSR_GLYPH_HEIGHT = 3'd3,
      CSR_GLYPH_COUNT  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_HOME,
      CMD_NEWLINE,
      CMD_PRINT
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCALE,
      BK_BASE,
      BK_LINES
   } back_state_type;

   typedef struct packed {
      logic [15:0] pitch;
      logic [7:0]  chars;
      logic [3:0]  width;
      logic [4:0]  height;
      logic [8:0]  count;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [7:0]         glyph;
      logic [FONT_AW-1:0] addr;
      logic [7:0]         data;
   } cmd_type;

   typedef struct packed {
      logic [OFFS_W-1:0] offs;
      logic [7:0]        bits;
      logic              last;
   } rsp_type;

   function automatic logic [3:0] eff_width(input logic [3:0] w);
      logic [3:0] r;
      if (w == 4'd0) r = 4'd1;
      else if (w > 4'd8) r = 4'd8;
      else r = w;
      return r;
   endfunction

   function automatic logic [4:0] eff_height(input logic [4:0] h);
      logic [4:0] r;
      if (h == 5'd0) r = 5'd1;
      else if (h > 5'(HEIGHT_LIMIT)) r = 5'(HEIGHT_LIMIT);
      else r = h;
      return r;
   endfunction

endpackage

// ===== hw/rtl/tgr_front.sv =====
module tgr_front
   import tgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_char_code,
   input  logic [FONT_AW-1:0] req_font_addr,
   input  logic [7:0]        req_font_byte,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output cfg_type           cfg,
   output logic              q_push,
   output cmd_type           q_cmd,
   input  logic              q_full
);

   cfg_type cfg_ff, cfg_in;
   logic    vld_ff, vld_in;
   cmd_type cmd_ff, cmd_in;
   logic    take;
   logic    known;

   assign req_full = vld_ff && q_full;
   assign take     = req_push && !req_full;
   assign q_push   = vld_ff && !q_full;
   assign q_cmd    = cmd_ff;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PITCH:        cfg_in.pitch  = csr_wdata;
            CSR_CHARS:        cfg_in.chars  = csr_wdata[7:0];
            CSR_GLYPH_WIDTH:  cfg_in.width  = csr_wdata[3:0];
            CSR_GLYPH_HEIGHT: cfg_in.height = csr_wdata[4:0];
            CSR_GLYPH_COUNT:  cfg_in.count  = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd_in       = cmd_ff;
      known        = 1'b1;
      cmd_in.glyph = 8'd0;
      cmd_in.addr  = req_font_addr;
      cmd_in.data  = req_font_byte;
      case (func_type'(req_func))
         FUNC_LOAD: cmd_in.kind = CMD_LOAD;
         FUNC_HOME: cmd_in.kind = CMD_HOME;
         FUNC_PRINT: begin
            if (req_char_code == CHAR_NEWLINE) begin
               cmd_in.kind = CMD_NEWLINE;
            end else begin
               cmd_in.kind = CMD_PRINT;
               if ((req_char_code inside {[CHAR_FIRST:CHAR_LAST]}) &&
                   ({1'b0, req_char_code} < cfg_ff.count) &&
                   ({1'b0, req_char_code} < 9'(MAX_GLYPHS))) begin
                  cmd_in.glyph = req_char_code;
               end
            end
         end
         default: known = 1'b0;
      endcase
      if (!take) begin
         cmd_in = cmd_ff;
      end
      vld_in = take ? known : (vld_ff && q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cfg_ff <= '{pitch: 16'd4096, chars: 8'd113, width: 4'd8, height: 5'd16,
                     count: 9'd256};
      end else begin
         vld_ff <= vld_in;
         cfg_ff <= cfg_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== hw/rtl/tgr_cmd_queue.sv =====
module tgr_cmd_queue
   import tgr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   cmd_type           slot_ff [CMD_DEPTH];
   logic [CMD_PW-1:0] wr_ff, wr_in;
   logic [CMD_PW-1:0] rd_ff, rd_in;
   logic [CMD_PW:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == (CMD_PW+1)'(CMD_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (CMD_PW+1)'(do_push) - (CMD_PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/tgr_back.sv =====
module tgr_back
   import tgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  cmd_type           q_head,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [OFFS_W-1:0] rsp_row_offset,
   output logic [7:0]        rsp_row_bits,
   output logic              rsp_last
);

   back_state_type state_ff, state_in;

   logic [7:0]        col_ff, col_in;
   logic [7:0]        row_ff, row_in;
   logic [7:0]        glyph_ff, glyph_in;
   logic [12:0]       rowh_ff, rowh_in;
   logic [13:0]       colw_ff, colw_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   logic [LINE_W-1:0] line_ff, line_in;

   logic              s_vld_ff, s_vld_in;
   logic [OFFS_W-1:0] s_offs_ff, s_offs_in;
   logic              s_last_ff, s_last_in;

   logic [7:0]        font_mem [FONT_DEPTH];
   logic [7:0]        rd_data_ff;
   logic              mem_we;
   logic              rd_en;
   logic [FONT_AW-1:0] rd_addr;

   rsp_type           rsp_q_ff [RSP_DEPTH];
   logic [RSP_PW-1:0] rsp_wr_ff, rsp_rd_ff;
   logic [RSP_PW:0]   rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_take;
   rsp_type           rsp_new;

   logic [3:0]        w_eff;
   logic [4:0]        h_eff;
   logic              room;
   logic              line_last;
   logic [7:0]        col_next;
   logic [28:0]       prod;

   assign w_eff     = eff_width(cfg.width);
   assign h_eff     = eff_height(cfg.height);
   assign room      = (rsp_cnt_ff + (RSP_PW+1)'(s_vld_ff)) < (RSP_PW+1)'(RSP_DEPTH);
   assign line_last = ({1'b0, line_ff} == (h_eff - 5'd1));
   assign col_next  = col_ff + 8'd1;
   assign prod      = rowh_ff * cfg.pitch;
   assign rd_addr   = {glyph_ff, line_ff};

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      glyph_in  = glyph_ff;
      rowh_in   = rowh_ff;
      colw_in   = colw_ff;
      offs_in   = offs_ff;
      line_in   = line_ff;
      s_vld_in  = 1'b0;
      s_offs_in = s_offs_ff;
      s_last_in = s_last_ff;
      q_pop     = 1'b0;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  CMD_LOAD: mem_we = 1'b1;
                  CMD_HOME: begin
                     col_in = 8'd0;
                     row_in = 8'd0;
                  end
                  CMD_NEWLINE: begin
                     col_in = 8'd0;
                     row_in = row_ff + 8'd1;
                  end
                  CMD_PRINT: begin
                     glyph_in = q_head.glyph;
                     state_in = BK_SCALE;
                  end
                  default: ;
               endcase
            end
         end
         BK_SCALE: begin
            rowh_in  = 13'(row_ff) * 13'(h_eff) + 13'(MARGIN_CELLS);
            colw_in  = (14'(col_ff) * (14'(w_eff) + 14'd1) + 14'(MARGIN_CELLS))
                       * 14'(BYTES_PER_PIXEL);
            state_in = BK_BASE;
         end
         BK_BASE: begin
            offs_in  = prod[OFFS_W-1:0] + OFFS_W'(colw_ff);
            line_in  = '0;
            state_in = BK_LINES;
         end
         BK_LINES: begin
            if (room) begin
               rd_en     = 1'b1;
               s_vld_in  = 1'b1;
               s_offs_in = offs_ff;
               s_last_in = line_last;
               offs_in   = offs_ff + OFFS_W'(cfg.pitch);
               line_in   = line_ff + 1'b1;
               if (line_last) begin
                  state_in = BK_IDLE;
                  if (col_next >= cfg.chars || col_next == 8'd0) begin
                     col_in = 8'd0;
                     row_in = row_ff + 8'd1;
                  end else begin
                     col_in = col_next;
                  end
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         s_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         s_vld_ff <= s_vld_in;
      end
      glyph_ff  <= glyph_in;
      rowh_ff   <= rowh_in;
      colw_ff   <= colw_in;
      offs_ff   <= offs_in;
      line_ff   <= line_in;
      s_offs_ff <= s_offs_in;
      s_last_ff <= s_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         font_mem[q_head.addr] <= q_head.data;
      end
      if (rd_en) begin
         rd_data_ff <= font_mem[rd_addr];
      end
   end

   assign rsp_take = rsp_pop && !rsp_empty;
   assign rsp_new  = '{offs: s_offs_ff, bits: rd_data_ff >> (4'd8 - w_eff),
                       last: s_last_ff};
   assign rsp_cnt_in = rsp_cnt_ff + (RSP_PW+1)'(s_vld_ff) - (RSP_PW+1)'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff  <= '0;
         rsp_rd_ff  <= '0;
         rsp_cnt_ff <= '0;
      end else begin
         if (s_vld_ff) rsp_wr_ff <= rsp_wr_ff + 1'b1;
         if (rsp_take) rsp_rd_ff <= rsp_rd_ff + 1'b1;
         rsp_cnt_ff <= rsp_cnt_in;
      end
      if (s_vld_ff) begin
         rsp_q_ff[rsp_wr_ff] <= rsp_new;
      end
   end

   assign rsp_empty      = (rsp_cnt_ff == '0);
   assign rsp_row_offset = rsp_q_ff[rsp_rd_ff].offs;
   assign rsp_row_bits   = rsp_q_ff[rsp_rd_ff].bits;
   assign rsp_last       = rsp_q_ff[rsp_rd_ff].last;

endmodule

// ===== hw/rtl/text_glyph_row_renderer.sv =====
// channel   direction  handshake            payload
// req       in         push / full          func, char_code, font_addr, font_byte
// rsp       out        empty / pop          row_offset, row_bits, last
// csr       in         we (no wait)         index, wdata
//
// A printed glyph is popped in the idle state, its first line offset is formed in the
// scale and base states, then the font store is read once per line. Load, home, newline
// items are handled when popped. A push passes the front end register and the command
// queue before the back end sees it. Reset is synchronous, clears cursor, queues and
// state and loads default settings; the font store is not cleared. A full result queue
// stalls line reads only; the front end takes items until the command queue fills.
module text_glyph_row_renderer
   import tgr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_func,
   input  logic [7:0]        req_char_code,
   input  logic [FONT_AW-1:0] req_font_addr,
   input  logic [7:0]        req_font_byte,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [OFFS_W-1:0] rsp_row_offset,
   output logic [7:0]        rsp_row_bits,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   cfg_type cfg;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_cmd, q_head;

   tgr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_font_addr (req_font_addr),
      .req_font_byte (req_font_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cfg           (cfg),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .q_full        (q_full)
   );

   tgr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   tgr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_row_offset (rsp_row_offset),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== hw/rtl/tgr_checker.sv =====
module tgr_checker
   import tgr_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic [OFFS_W-1:0] rsp_row_offset,
   input logic [7:0]        rsp_row_bits,
   input logic              rsp_last,
   input logic              csr_we,
   input logic [2:0]        csr_index,
   input logic [15:0]       csr_wdata
);

   logic [15:0]       pitch_ff, pitch_in;
   logic [3:0]        width_ff, width_in;
   logic              exp_vld_ff, exp_vld_in;
   logic [OFFS_W-1:0] exp_ff, exp_in;
   logic [3:0]        w_eff;
   logic              take;

   assign take  = rsp_pop && !rsp_empty;
   assign w_eff = eff_width(width_ff);

   always_comb begin
      pitch_in   = pitch_ff;
      width_in   = width_ff;
      exp_vld_in = exp_vld_ff;
      exp_in     = exp_ff;
      if (csr_we && csr_index == CSR_PITCH) pitch_in = csr_wdata;
      if (csr_we && csr_index == CSR_GLYPH_WIDTH) width_in = csr_wdata[3:0];
      if (take) begin
         exp_vld_in = !rsp_last;
         exp_in     = rsp_row_offset + OFFS_W'(pitch_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff   <= 16'd4096;
         width_ff   <= 4'd8;
         exp_vld_ff <= 1'b0;
      end else begin
         pitch_ff   <= pitch_in;
         width_ff   <= width_in;
         exp_vld_ff <= exp_vld_in;
      end
      exp_ff <= exp_in;
   end

   a_reset_state: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_row_offset) &&
      $stable(rsp_row_bits) && $stable(rsp_last))
      else $error("waiting item changed");

   a_line_step: assert property (@(posedge clock) disable iff (reset)
      take && exp_vld_ff |-> rsp_row_offset == exp_ff)
      else $error("glyph line offset not one pitch past the previous line");

   a_bits_fit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> {1'b0, rsp_row_bits} < (9'd1 << w_eff))
      else $error("row bits wider than glyph width");

endmodule

bind text_glyph_row_renderer tgr_checker u_chk (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tgr_pkg::*;

   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 40;
   localparam int MAX_GAP        = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_func = '0;
   logic [7:0]        req_char_code = '0;
   logic [FONT_AW-1:0] req_font_addr = '0;
   logic [7:0]        req_font_byte = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic [OFFS_W-1:0] rsp_row_offset;
   logic [7:0]        rsp_row_bits;
   logic              rsp_last;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;

   logic holdoff_start = 1'b0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   hold_left = 0;

   bit [15:0] pitch_reg  = 16'd4096;
   bit [7:0]  chars_reg  = 8'd113;
   bit [3:0]  width_reg  = 4'd8;
   bit [4:0]  height_reg = 5'd16;
   bit [8:0]  count_reg  = 9'd256;
   bit [7:0]  cur_col = '0;
   bit [7:0]  cur_row = '0;
   bit [7:0]  font_mem [FONT_DEPTH];
   bit        font_known [FONT_DEPTH];
   rsp_type   lines_due [$];

   text_glyph_row_renderer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_font_addr  (req_font_addr),
      .req_font_byte  (req_font_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_row_offset (rsp_row_offset),
      .rsp_row_bits   (rsp_row_bits),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int glyph_lines();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return height_reg;
   endfunction

   function automatic int glyph_pixels();
      if (width_reg == 0) return 1;
      if (width_reg > 8) return 8;
      return width_reg;
   endfunction

   function automatic bit [7:0] glyph_slot(input bit [7:0] code);
      if (code >= CHAR_FIRST && code <= CHAR_LAST && code < count_reg && code < MAX_GLYPHS)
         return code;
      return 8'd0;
   endfunction

   function automatic void advance_console(input bit [1:0] func, input bit [7:0] code,
                                           input bit [11:0] addr, input bit [7:0] data);
      int h;
      int w;
      bit [7:0] g;
      bit [11:0] a;
      longint unsigned base;
      rsp_type due;
      case (func)
         FUNC_LOAD: begin
            font_mem[addr] = data;
            font_known[addr] = 1'b1;
         end
         FUNC_HOME: begin
            cur_col = '0;
            cur_row = '0;
         end
         FUNC_PRINT: begin
            if (code == CHAR_NEWLINE) begin
               cur_col = '0;
               cur_row++;
            end else begin
               h = glyph_lines();
               w = glyph_pixels();
               g = glyph_slot(code);
               base = (longint'(cur_row) * h + MARGIN_CELLS) * pitch_reg
                    + (longint'(cur_col) * (w + 1) + MARGIN_CELLS) * BYTES_PER_PIXEL;
               for (int ln = 0; ln < h; ln++) begin
                  a = 12'(g * LINE_SLOTS + ln);
                  due.offs = OFFS_W'(base + longint'(ln) * pitch_reg);
                  due.bits = 8'(font_mem[a] >> (8 - w));
                  due.last = (ln == h - 1);
                  lines_due.push_back(due);
               end
               cur_col++;
               if (cur_col >= chars_reg || cur_col == 0) begin
                  cur_col = '0;
                  cur_row++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic push_item(input bit [1:0] func, input bit [7:0] code,
                            input bit [11:0] addr, input bit [7:0] data);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_func      <= func;
      req_char_code <= code;
      req_font_addr <= addr;
      req_font_byte <= data;
      do @(posedge clock); while (req_full);
      advance_console(func, code, addr, data);
   endtask

   task automatic print_char(input bit [7:0] code);
      int h;
      bit [11:0] a;
      h = glyph_lines();
      if (code != CHAR_NEWLINE) begin
         for (int ln = 0; ln < h; ln++) begin
            a = 12'(glyph_slot(code) * LINE_SLOTS + ln);
            if (!font_known[a]) push_item(FUNC_LOAD, 8'($urandom), a, 8'($urandom));
         end
      end
      push_item(FUNC_PRINT, code, 12'($urandom), 8'($urandom));
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (lines_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input bit [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_PITCH:        pitch_reg  = value;
         CSR_CHARS:        chars_reg  = value[7:0];
         CSR_GLYPH_WIDTH:  width_reg  = value[3:0];
         CSR_GLYPH_HEIGHT: height_reg = value[4:0];
         CSR_GLYPH_COUNT:  count_reg  = value[8:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input bit [15:0] pitch, input bit [7:0] chars,
                                 input bit [3:0] width, input bit [4:0] height,
                                 input bit [8:0] count);
      settle();
      write_csr(CSR_PITCH, pitch);
      write_csr(CSR_CHARS, 16'(chars));
      write_csr(CSR_GLYPH_WIDTH, 16'(width));
      write_csr(CSR_GLYPH_HEIGHT, 16'(height));
      write_csr(CSR_GLYPH_COUNT, 16'(count));
      csr_we <= 1'b0;
   endtask

   task automatic random_item();
      bit [7:0] pool [5] = '{CHAR_FIRST, 8'h41, 8'h61, 8'h7D, CHAR_LAST};
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) print_char(pool[$urandom_range(4)]);
      else if (pick < 67) print_char(8'($urandom));
      else if (pick < 74) print_char(CHAR_NEWLINE);
      else if (pick < 88) push_item(FUNC_LOAD, 8'($urandom), 12'($urandom), 8'($urandom));
      else if (pick < 94) push_item(FUNC_HOME, 8'($urandom), 12'($urandom), 8'($urandom));
      else push_item(FUNC_SPARE, 8'($urandom), 12'($urandom), 8'($urandom));
   endtask

   task automatic test_default_font();
      print_char(8'h41);
      print_char(8'h7F);
      print_char(8'h00);
      print_char(8'hFF);
      print_char(CHAR_NEWLINE);
      push_item(FUNC_SPARE, 8'h41, 12'hFFF, 8'hFF);
      print_char(8'h41);
      push_item(FUNC_HOME, 8'h00, 12'h000, 8'h00);
      print_char(8'h41);
   endtask

   task automatic test_register_extremes();
      apply_settings(16'h0000, 8'd1, 4'd1, 5'd1, 9'd1);
      print_char(8'h42);
      print_char(CHAR_LAST);
      apply_settings(16'hFFFF, 8'd255, 4'd15, 5'd31, 9'd511);
      print_char(CHAR_LAST);
      apply_settings(16'hFFFF, 8'd0, 4'd0, 5'd0, 9'd0);
      print_char(8'h78);
      print_char(8'h79);
      apply_settings(16'h1234, 8'd2, 4'd8, 5'd2, 9'd126);
      print_char(CHAR_LAST);
      print_char(8'h7D);
      print_char(8'h61);
      print_char(CHAR_FIRST);
   endtask

   task automatic test_random_traffic();
      int idle_mix [4] = '{0, 65, 0, 36};
      int stall_mix [4] = '{0, 0, 65, 36};
      for (int ph = 0; ph < 4; ph++) begin
         apply_settings(16'($urandom),
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6)),
                        4'($urandom),
                        ($urandom_range(4) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4)),
                        ($urandom_range(2) == 0) ? 9'($urandom) : 9'($urandom_range(96, 200)));
         send_idle_pct = idle_mix[ph];
         rsp_stall_pct = stall_mix[ph];
         repeat (20) random_item();
      end
   endtask

   task automatic test_backpressure();
      apply_settings(16'd640, 8'd80, 4'd8, 5'd16, 9'd256);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_start <= 1'b1;
      @(posedge clock);
      holdoff_start <= 1'b0;
      repeat (12) print_char(8'h41);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (lines_due.size() == 0) begin
               $display("%0t: unexpected line, expected none, actual offset %h bits %h last %b",
                        $time, rsp_row_offset, rsp_row_bits, rsp_last);
               mismatches++;
            end else begin
               want = lines_due.pop_front();
               if (rsp_row_offset !== want.offs) begin
                  $display("%0t: row_offset expected %h actual %h",
                           $time, want.offs, rsp_row_offset);
                  mismatches++;
               end
               if (rsp_row_bits !== want.bits) begin
                  $display("%0t: row_bits expected %h actual %h",
                           $time, want.bits, rsp_row_bits);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
                  mismatches++;
               end
            end
         end
         if (holdoff_start) hold_left = HOLDOFF_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_default_font();
      test_register_extremes();
      test_random_traffic();
      test_backpressure();
      settle();
      if (mismatches == 0 && lines_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
